FILE: rtl/core/crcfd_pkg.sv
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the frame deframer.
`default_nettype none

package crcfd_pkg;

   localparam logic [7:0]  SOF_BYTE   = 8'hA5;
   localparam logic [7:0]  EOF_BYTE   = 8'h55;
   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] TMO_RESET  = 16'd100;
   localparam logic [15:0] IDLE_MAX   = 16'hFFFF;
   localparam logic [15:0] LEN_SAT    = 16'd2047;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_SEQ     = 4'd1,
      PH_CMD     = 4'd2,
      PH_LEN_L   = 4'd3,
      PH_LEN_H   = 4'd4,
      PH_PAYLOAD = 4'd5,
      PH_CRC_L   = 4'd6,
      PH_CRC_H   = 4'd7,
      PH_END     = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      EV_PAYLOAD = 2'd0,
      EV_ACCEPT  = 2'd1,
      EV_NACK    = 2'd2
   } event_type;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      event_type   event_res;
      logic [7:0]  frame_seq;
      logic [7:0]  frame_command;
      logic [10:0] frame_length;
      logic [7:0]  payload_value;
      logic [9:0]  payload_index;
      logic        payload_last;
   } rsp_type;

   // MSB-first CRC, one data byte per call.
   function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] v;
      v = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (v[15]) begin
            v = {v[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[14:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/crcfd_in_stage.sv
// Input register holding one request until the core takes it.
`default_nettype none

module crcfd_in_stage
   import crcfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_operation,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       take,
   output logic            item_valid,
   output req_type         item
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   assign req_ready  = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in          = 1'b1;
         item_in.operation = op_type'(req_operation);
         item_in.rx_byte   = req_rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/crcfd_core.sv
// Deframing state machine, header/length capture, CRC update and timeout.
`default_nettype none

module crcfd_core
   import crcfd_pkg::*;
#(
   parameter int MAX_PAYLOAD = 1024
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        item_valid,
   input  wire req_type     item,
   input  wire logic        slot_free,
   output logic             take,
   output logic             res_valid,
   output rsp_type          res
);

   localparam int CNT_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

   phase_type        phase_ff, phase_in;
   logic [7:0]       seq_ff, seq_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [15:0]      len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       rcrc_lo_ff, rcrc_lo_in;
   logic [7:0]       rcrc_hi_ff, rcrc_hi_in;
   logic [15:0]      idle_ff, idle_in;
   logic [15:0]      tmo_ff;

   logic [15:0] crc_next;
   logic [15:0] idle_inc;
   logic        tmo_hit;
   logic [15:0] len_new;
   logic        len_over;
   logic [16:0] idx_plus;
   logic        pay_last;
   logic        frame_ok;
   logic        is_tick;

   assign take     = item_valid && slot_free;
   assign is_tick  = (item.operation == OP_TICK);
   assign crc_next = crc_ccitt_step(crc_ff, item.rx_byte);
   assign idle_inc = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
   assign tmo_hit  = (idle_inc >= tmo_ff);
   assign len_new  = (phase_ff == PH_LEN_H) ? {item.rx_byte, len_ff[7:0]} : len_ff;
   assign len_over = (len_new > MAX_LEN);
   assign idx_plus = 17'(cnt_ff) + 17'd1;
   assign pay_last = (idx_plus == {1'b0, len_ff});
   assign frame_ok = (item.rx_byte == EOF_BYTE) && ({rcrc_hi_ff, rcrc_lo_ff} == crc_ff);

   // next state
   always_comb begin
      phase_in   = phase_ff;
      seq_in     = seq_ff;
      cmd_in     = cmd_ff;
      len_in     = len_ff;
      cnt_in     = cnt_ff;
      crc_in     = crc_ff;
      rcrc_lo_in = rcrc_lo_ff;
      rcrc_hi_in = rcrc_hi_ff;
      idle_in    = idle_ff;
      if (is_tick) begin
         if (phase_ff != PH_HUNT) begin
            if (tmo_hit) begin
               phase_in = PH_HUNT;
               idle_in  = 16'd0;
            end else begin
               idle_in = idle_inc;
            end
         end
      end else begin
         idle_in = 16'd0;
         case (phase_ff)
            PH_HUNT: begin
               if (item.rx_byte == SOF_BYTE) begin
                  crc_in   = CRC_INIT;
                  cnt_in   = '0;
                  phase_in = PH_SEQ;
               end
            end
            PH_SEQ: begin
               seq_in   = item.rx_byte;
               crc_in   = crc_next;
               phase_in = PH_CMD;
            end
            PH_CMD: begin
               cmd_in   = item.rx_byte;
               crc_in   = crc_next;
               phase_in = PH_LEN_L;
            end
            PH_LEN_L: begin
               len_in   = {8'h00, item.rx_byte};
               crc_in   = crc_next;
               phase_in = PH_LEN_H;
            end
            PH_LEN_H: begin
               len_in = len_new;
               crc_in = crc_next;
               cnt_in = '0;
               if (len_over) begin
                  phase_in = PH_HUNT;
               end else if (len_new == 16'd0) begin
                  phase_in = PH_CRC_L;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               crc_in = crc_next;
               cnt_in = idx_plus[CNT_W-1:0];
               if (pay_last) begin
                  phase_in = PH_CRC_L;
               end
            end
            PH_CRC_L: begin
               rcrc_lo_in = item.rx_byte;
               phase_in   = PH_CRC_H;
            end
            PH_CRC_H: begin
               rcrc_hi_in = item.rx_byte;
               phase_in   = PH_END;
            end
            PH_END: begin
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // result
   always_comb begin
      logic      emit;
      event_type ev;
      logic [15:0] idx16;
      emit  = 1'b0;
      ev    = EV_NACK;
      idx16 = 16'(cnt_ff);
      if (is_tick) begin
         emit = (phase_ff != PH_HUNT) && tmo_hit && (phase_ff >= PH_PAYLOAD);
      end else begin
         case (phase_ff)
            PH_LEN_H: begin
               emit = len_over;
            end
            PH_PAYLOAD: begin
               emit = 1'b1;
               ev   = EV_PAYLOAD;
            end
            PH_END: begin
               emit = 1'b1;
               ev   = frame_ok ? EV_ACCEPT : EV_NACK;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
      res_valid         = take && emit;
      res.event_res     = ev;
      res.frame_seq     = seq_ff;
      res.frame_command = cmd_ff;
      res.frame_length  = (len_new > LEN_SAT) ? 11'h7FF : len_new[10:0];
      if (ev == EV_PAYLOAD) begin
         res.payload_value = item.rx_byte;
         res.payload_index = idx16[9:0];
         res.payload_last  = pay_last;
      end else begin
         res.payload_value = 8'h00;
         res.payload_index = 10'd0;
         res.payload_last  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         seq_ff     <= 8'h00;
         cmd_ff     <= 8'h00;
         len_ff     <= 16'd0;
         cnt_ff     <= '0;
         crc_ff     <= CRC_INIT;
         rcrc_lo_ff <= 8'h00;
         rcrc_hi_ff <= 8'h00;
         idle_ff    <= 16'd0;
         tmo_ff     <= TMO_RESET;
      end else begin
         if (take) begin
            phase_ff   <= phase_in;
            seq_ff     <= seq_in;
            cmd_ff     <= cmd_in;
            len_ff     <= len_in;
            cnt_ff     <= cnt_in;
            crc_ff     <= crc_in;
            rcrc_lo_ff <= rcrc_lo_in;
            rcrc_hi_ff <= rcrc_hi_in;
            idle_ff    <= idle_in;
         end
         if (csr_wr_en) begin
            tmo_ff <= csr_wr_data;
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/crcfd_out_stage.sv
// Result register driving the response channel.
`default_nettype none

module crcfd_out_stage
   import crcfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        res_valid,
   input  wire rsp_type     res,
   output logic             slot_free,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_event_res,
   output logic [7:0]       rsp_frame_seq,
   output logic [7:0]       rsp_frame_command,
   output logic [10:0]      rsp_frame_length,
   output logic [7:0]       rsp_payload_value,
   output logic [9:0]       rsp_payload_index,
   output logic             rsp_payload_last
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (slot_free) begin
         valid_in = res_valid;
         if (res_valid) begin
            data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_event_res     = data_ff.event_res;
   assign rsp_frame_seq     = data_ff.frame_seq;
   assign rsp_frame_command = data_ff.frame_command;
   assign rsp_frame_length  = data_ff.frame_length;
   assign rsp_payload_value = data_ff.payload_value;
   assign rsp_payload_index = data_ff.payload_index;
   assign rsp_payload_last  = data_ff.payload_last;

endmodule

`default_nettype wire

FILE: rtl/core/crc16_frame_deframer_top.sv
// Top level of the CRC-16 frame deframer.
// Each request is a received byte or a timer tick. The deframer hunts for 0xA5, reads
// sequence, command and a little-endian length, forwards each payload byte as a response,
// then checks the little-endian CRC-16/CCITT-FALSE (over header and payload) and the 0x55
// end byte, answering accept or nack. Oversized length, bad CRC/end byte or a byte timeout
// after the header give a nack; a timeout inside the header drops the frame silently.
// A request is taken every cycle while responses drain: a request register, combinational
// state-machine logic with a byte-wide CRC update, and a response register, so a response
// is registered after passing the request register. csr_wr_data sets the byte timeout in
// ticks (reset 100) and should be written only while the block is idle.
`default_nettype none

module crc16_frame_deframer_top
   import crcfd_pkg::*;
#(
   parameter int MAX_PAYLOAD = 1024
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_event_res,
   output logic [7:0]       rsp_frame_seq,
   output logic [7:0]       rsp_frame_command,
   output logic [10:0]      rsp_frame_length,
   output logic [7:0]       rsp_payload_value,
   output logic [9:0]       rsp_payload_index,
   output logic             rsp_payload_last
);

   logic    take;
   logic    item_valid;
   req_type item;
   logic    slot_free;
   logic    res_valid;
   rsp_type res;

   crcfd_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_rx_byte   (req_rx_byte),
      .take          (take),
      .item_valid    (item_valid),
      .item          (item)
   );

   crcfd_core #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (item),
      .slot_free   (slot_free),
      .take        (take),
      .res_valid   (res_valid),
      .res         (res)
   );

   crcfd_out_stage u_out (
      .clock             (clock),
      .reset             (reset),
      .res_valid         (res_valid),
      .res               (res),
      .slot_free         (slot_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_res     (rsp_event_res),
      .rsp_frame_seq     (rsp_frame_seq),
      .rsp_frame_command (rsp_frame_command),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_payload_value (rsp_payload_value),
      .rsp_payload_index (rsp_payload_index),
      .rsp_payload_last  (rsp_payload_last)
   );

endmodule

`default_nettype wire
